// ===== rtl/core/md5_pkg.sv =====
// md5_pkg: shared types, constants and round functions of the md5 engine
// depends on nothing; imported by md5_hash_engine
`default_nettype none

package md5_pkg;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_PREFETCH = 6'b000010,
    ST_ROUND    = 6'b000100,
    ST_FINAL    = 6'b001000,
    ST_PAD      = 6'b010000,
    ST_EMIT     = 6'b100000
  } md5_state_t;

  // which kind of padding byte goes next
  typedef enum logic [1:0] {
    PAD_MARK = 2'd0,
    PAD_ZERO = 2'd1,
    PAD_LEN  = 2'd2
  } md5_pad_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET    = 6'd56;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_LEN_BYTE = 3'd7;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    idx = r4;
      2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
      default: idx = 4'(r4 * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/md5_hash_engine.sv =====
// md5_hash_engine: byte-streaming md5 digest with one shared round unit
// depends on md5_pkg (state types, round constants, rotate helper)
//
// usage:
//   in_*  : one message byte per transaction. in_tdata carries the byte,
//           in_tuser says whether the byte is present, in_tlast ends the
//           message. a transaction with neither byte nor last changes nothing.
//   out_* : one 128-bit digest per message, low half first in the bits.
// timing:
//   bytes are taken one per cycle while in_tready is high; every 64th byte
//   starts a compression (one prefetch, 64 rounds through the single round
//   adder, one chaining add), during which in_tready stays low.
//   after the last transaction the padding is written one byte per cycle
//   (at most 72 bytes) with one or two compressions in between; the
//   digest then goes to the output register as soon as it is free.
// the digest sits in an output register, so the next message streams in
//   while a stalled receiver holds off; only the end of that next message
//   waits for the register to drain.
// reset clears the sequencer, the bit count, the fill index and loads the
//   initial chaining value; the block buffer is not cleared.
`default_nettype none

module md5_hash_engine
  import md5_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tuser,   // [0] byte_present
  input  wire logic         in_tlast,   // last
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // [63:0] digest_low, [127:64] digest_high
);

  md5_state_t state_r, state_nxt;

  // chaining value and working registers
  logic [31:0] cv_a_r, cv_b_r, cv_c_r, cv_d_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;

  logic [63:0] bit_cnt_r;
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;

  // padding progress
  logic        pad_on_r;
  logic        pad_done_r;
  md5_pad_t    pad_phase_r;
  logic [2:0]  len_idx_r;

  // block buffer: 16 little-endian words, byte writes, registered read
  logic [31:0] blk_mem [16];
  logic [31:0] word_q;
  logic [3:0]  rd_addr;

  logic [127:0] out_data_r;
  logic         out_valid_r;

  logic        in_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [5:0]  fill_inc;
  logic        emit_go;

  // shared round unit
  logic [31:0] f_val;
  logic [31:0] rnd_sum;
  logic [31:0] b_new;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign fill_inc   = fill_r + 6'd1;
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // byte that goes into the buffer this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = in_tdata;
    if (state_r == ST_IDLE) begin
      wr_en = in_acc && in_tuser;
    end else if (state_r == ST_PAD) begin
      wr_en = 1'b1;
      case (pad_phase_r)
        PAD_MARK: wr_byte = PAD_MARK_BYTE;
        PAD_LEN:  wr_byte = bit_cnt_r[len_idx_r*8 +: 8];
        default:  wr_byte = 8'h00;
      endcase
    end
  end

  // next message word: the next round's word during the rounds, word 0 otherwise
  assign rd_addr = (state_r == ST_ROUND) ? msg_index(rnd_r + 6'd1) : msg_index(6'd0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_mem[fill_r[5:2]][fill_r[1:0]*8 +: 8] <= wr_byte;
    end
    word_q <= blk_mem[rd_addr];
  end

  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = (wb_r & wc_r) | (~wb_r & wd_r);
      2'd1:    f_val = (wd_r & wb_r) | (~wd_r & wc_r);
      2'd2:    f_val = wb_r ^ wc_r ^ wd_r;
      default: f_val = wc_r ^ (wb_r | ~wd_r);
    endcase
    rnd_sum = wa_r + f_val + round_const(rnd_r) + word_q;
    b_new   = wb_r + rotl32(rnd_sum, rot_amount(rnd_r));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser && fill_inc == 6'd0) begin
            state_nxt = ST_PREFETCH;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PREFETCH: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (pad_done_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_on_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill_inc == 6'd0) begin
          state_nxt = ST_PREFETCH;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cv_a_r      <= IV_A;
      cv_b_r      <= IV_B;
      cv_c_r      <= IV_C;
      cv_d_r      <= IV_D;
      bit_cnt_r   <= 64'd0;
      fill_r      <= 6'd0;
      rnd_r       <= 6'd0;
      pad_on_r    <= 1'b0;
      pad_done_r  <= 1'b0;
      pad_phase_r <= PAD_MARK;
      len_idx_r   <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (wr_en) begin
        fill_r <= fill_inc;
      end

      if (state_r == ST_IDLE && in_acc) begin
        if (in_tuser) begin
          bit_cnt_r <= bit_cnt_r + 64'd8;
        end
        if (in_tlast) begin
          pad_on_r    <= 1'b1;
          pad_phase_r <= PAD_MARK;
          len_idx_r   <= 3'd0;
        end
      end

      // walk the padding: marker, zeros up to the length field, 8 count bytes
      if (state_r == ST_PAD) begin
        case (pad_phase_r) inside
          PAD_MARK, PAD_ZERO: begin
            pad_phase_r <= (fill_inc == LEN_OFFSET) ? PAD_LEN : PAD_ZERO;
          end
          default: begin
            len_idx_r <= len_idx_r + 3'd1;
            if (len_idx_r == LAST_LEN_BYTE) begin
              pad_done_r <= 1'b1;
            end
          end
        endcase
      end

      if (state_r == ST_PREFETCH) begin
        wa_r  <= cv_a_r;
        wb_r  <= cv_b_r;
        wc_r  <= cv_c_r;
        wd_r  <= cv_d_r;
        rnd_r <= 6'd0;
      end

      if (state_r == ST_ROUND) begin
        wa_r  <= wd_r;
        wd_r  <= wc_r;
        wc_r  <= wb_r;
        wb_r  <= b_new;
        rnd_r <= rnd_r + 6'd1;
      end

      if (state_r == ST_FINAL) begin
        cv_a_r <= cv_a_r + wa_r;
        cv_b_r <= cv_b_r + wb_r;
        cv_c_r <= cv_c_r + wc_r;
        cv_d_r <= cv_d_r + wd_r;
      end

      // hand the digest over and start a fresh message
      if (emit_go) begin
        out_valid_r <= 1'b1;
        cv_a_r      <= IV_A;
        cv_b_r      <= IV_B;
        cv_c_r      <= IV_C;
        cv_d_r      <= IV_D;
        bit_cnt_r   <= 64'd0;
        fill_r      <= 6'd0;
        pad_on_r    <= 1'b0;
        pad_done_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= {cv_d_r, cv_c_r, cv_b_r, cv_a_r};
    end
  end

`ifndef NO_ASSERTIONS
  // a compression only ever starts on a completely written block
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PREFETCH |-> fill_r == 6'd0)
    else $error("compression started on a partial block");

  // the last round always hands over to the chaining add
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == LAST_ROUND) |=> state_r == ST_FINAL)
    else $error("round counter did not end the compression");

  // handing over a digest leaves a clean message state behind
  a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_tvalid && bit_cnt_r == 64'd0 && fill_r == 6'd0 && !pad_on_r))
    else $error("message state not cleared after digest");
`endif

endmodule

`default_nettype wire
